// ===== design/sme_pkg.sv =====
// Shared constants for the stack machine engine: stack geometry, operation
// codes and error codes. Depends on nothing.
package sme_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_POP  = 3'd1;
    localparam logic [2:0] OP_SWAP = 3'd2;
    localparam logic [2:0] OP_PEEK = 3'd3;
    localparam logic [2:0] OP_DUMP = 3'd4;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_ARG    = 3'd1;
    localparam logic [2:0] ERR_PEEK_EMPTY = 3'd2;
    localparam logic [2:0] ERR_POP_EMPTY  = 3'd3;
    localparam logic [2:0] ERR_SWAP_SHORT = 3'd4;
    localparam logic [2:0] ERR_FULL       = 3'd5;

endpackage

// ===== design/sme_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/stack_machine_engine.sv =====
// Top level of the stack machine engine: operation sequencer, entry counter
// and output register around the stack RAM.
// Depends on sme_pkg and sme_ram.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_func, i_push_value, i_arg_ok
//   out      source     o_out_valid / i_out_stall o_top_value, o_error_code, o_is_last
//
// Push and pop complete in the idle state; swap steps through SW1 to SW3,
// as the single RAM read port and single write port each serve two accesses
// in turn. Peek and an error pass through their own state, dump walks the
// entries paced by the RAM. A halted block still takes beats and drops them.
// Reset is synchronous and clears the count and the halt flag, not the RAM
// contents. A stalled output holds peek, dump and error; the read data waits.
module stack_machine_engine
    import sme_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_func,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic                     i_arg_ok,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_top_value,
    output logic [2:0]               o_error_code,
    output logic                     o_is_last
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SW1  = 7'b0000010,
        S_SW2  = 7'b0000100,
        S_SW3  = 7'b0001000,
        S_PEEK = 7'b0010000,
        S_DUMP = 7'b0100000,
        S_ERR  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_halted, n_halted;
    logic [2:0]         r_err, n_err;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [DATA_W-1:0]  r_tmp, n_tmp;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_value;
    logic [2:0]         r_out_code;
    logic               r_out_last;

    logic               w_in_acc;
    logic               w_out_free;
    logic [CNT_W-1:0]   w_cnt_m1, w_cnt_m2;
    logic               w_ram_we, w_ram_re;
    logic [ADDR_W-1:0]  w_ram_waddr, w_ram_raddr;
    logic [DATA_W-1:0]  w_ram_wdata, w_ram_rdata;
    logic               w_load;
    logic [DATA_W-1:0]  w_ld_value;
    logic [2:0]         w_ld_code;
    logic               w_ld_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cnt_m1   = r_count - CNT_W'(1);
    assign w_cnt_m2   = r_count - CNT_W'(2);

    sme_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_re   (w_ram_re),
        .i_raddr(w_ram_raddr),
        .o_rdata(w_ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_halted    = r_halted;
        n_err       = r_err;
        n_ptr       = r_ptr;
        n_tmp       = r_tmp;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_count[ADDR_W-1:0];
        w_ram_wdata = i_push_value;
        w_ram_re    = 1'b0;
        w_ram_raddr = w_cnt_m1[ADDR_W-1:0];
        w_load      = 1'b0;
        w_ld_value  = '0;
        w_ld_code   = ERR_NONE;
        w_ld_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && !r_halted) begin
                    unique case (i_func)
                        OP_PUSH: begin
                            if (!i_arg_ok) begin
                                n_err   = ERR_BAD_ARG;
                                n_state = S_ERR;
                            end else if (r_count == CNT_W'(STACK_DEPTH)) begin
                                n_err   = ERR_FULL;
                                n_state = S_ERR;
                            end else begin
                                w_ram_we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_err   = ERR_POP_EMPTY;
                                n_state = S_ERR;
                            end else begin
                                n_count = w_cnt_m1;
                            end
                        end
                        OP_SWAP: begin
                            if (r_count < CNT_W'(2)) begin
                                n_err   = ERR_SWAP_SHORT;
                                n_state = S_ERR;
                            end else begin
                                w_ram_re = 1'b1;
                                n_state  = S_SW1;
                            end
                        end
                        OP_PEEK: begin
                            if (r_count == '0) begin
                                n_err   = ERR_PEEK_EMPTY;
                                n_state = S_ERR;
                            end else begin
                                w_ram_re = 1'b1;
                                n_state  = S_PEEK;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count != '0) begin
                                w_ram_re = 1'b1;
                                n_ptr    = w_cnt_m1[ADDR_W-1:0];
                                n_state  = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SW1: begin
                n_tmp       = w_ram_rdata;
                w_ram_re    = 1'b1;
                w_ram_raddr = w_cnt_m2[ADDR_W-1:0];
                n_state     = S_SW2;
            end
            S_SW2: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = w_cnt_m1[ADDR_W-1:0];
                w_ram_wdata = w_ram_rdata;
                n_state     = S_SW3;
            end
            S_SW3: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = w_cnt_m2[ADDR_W-1:0];
                w_ram_wdata = r_tmp;
                n_state     = S_IDLE;
            end
            S_PEEK: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_ld_value = w_ram_rdata;
                    n_state    = S_IDLE;
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_ld_value = w_ram_rdata;
                    w_ld_last  = (r_ptr == '0);
                    if (r_ptr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr       = r_ptr - ADDR_W'(1);
                        w_ram_re    = 1'b1;
                        w_ram_raddr = r_ptr - ADDR_W'(1);
                    end
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_code = r_err;
                    n_halted  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_halted <= n_halted;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_err <= n_err;
        r_ptr <= n_ptr;
        r_tmp <= n_tmp;
        if (w_load) begin
            r_out_value <= w_ld_value;
            r_out_code  <= w_ld_code;
            r_out_last  <= w_ld_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_top_value  = r_out_value;
    assign o_error_code = r_out_code;
    assign o_is_last    = r_out_last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("Entry count exceeds the stack depth.");

    a_halt_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> $stable(r_count) && r_halted)
        else $error("A halted engine changed its entry count.");

    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_state == S_IDLE)
        else $error("A halted engine is still sequencing.");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != ERR_NONE) |-> (o_top_value == '0 && o_is_last))
        else $error("An error beat carries a value or is not marked last.");
`endif

endmodule
